// ===== design/depq_pkg.sv =====
// Shared constants and types for the double-ended priority queue.
`default_nettype none
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd2;

  // Broadcast from the top level to every cell in the cycle a word is taken.
  typedef struct packed {
    logic                     ins_en;   // insert with room left
    logic                     del_min;  // delete minimum on a non-empty store
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/depq_cell.sv =====
// One slot of the sorted array: holds a value, shifts right on insert, left on delete-min.
`default_nettype none
module depq_cell (
  input  wire logic                             clk,
  input  wire depq_pkg::cell_ctl_t              ctl,
  input  wire logic                             occ,       // slot holds a stored value
  input  wire logic                             tail,      // first free slot
  input  wire logic signed [depq_pkg::DATA_W-1:0] left_val,
  input  wire logic                             left_gt,
  input  wire logic signed [depq_pkg::DATA_W-1:0] right_val,
  output logic signed [depq_pkg::DATA_W-1:0]    val_o,
  output logic                                  gt_o
);

  logic signed [depq_pkg::DATA_W-1:0] val_r;
  logic signed [depq_pkg::DATA_W-1:0] val_nxt;

  // Stored value strictly above the new one: it moves up a slot.
  assign gt_o  = occ && (val_r > ctl.value);
  assign val_o = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && (gt_o || tail)) begin
      val_nxt = left_gt ? left_val : ctl.value;
    end else if (ctl.del_min && occ) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ===== design/double_ended_priority_queue_top.sv =====
// Top level of the double-ended priority queue: cell row, count and result register.
//
// Usage:
//   Input channel: drive in_command and in_value with start high; the word is
//   taken at the rising edge where start is high and busy is low. Commands:
//   insert, delete maximum, delete minimum; code 3 leaves the store as is.
//   Result channel: out_valid strobes for one cycle with out_max_value,
//   out_min_value, out_is_empty, out_entry_count and out_overflow for that word.
//   The cell row updates at the accepting edge; the next cycle (busy
//   high) reduces the row to max/min into the output register; the result
//   strobes in the cycle after that. No new word is taken while busy is
//   high, during the max reduction across the cell row after each update.
//   A new word may be taken in the cycle the previous result strobes.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Reset (rst_n low, synchronous) empties the store and clears busy and
//   out_valid; cell contents need no reset since the count gates every read.
//   An insert into a full store is dropped and reported with out_overflow.
`default_nettype none
module double_ended_priority_queue_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [depq_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [depq_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic signed [depq_pkg::DATA_W-1:0]       out_max_value,
  output logic signed [depq_pkg::DATA_W-1:0]       out_min_value,
  output logic                                     out_is_empty,
  output logic [depq_pkg::CNT_W-1:0]               out_entry_count,
  output logic                                     out_overflow
);

  localparam int N = depq_pkg::CAPACITY;
  localparam logic [depq_pkg::CNT_W-1:0] FULL = depq_pkg::CNT_W'(N);

  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [depq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        accept;
  depq_pkg::cell_ctl_t         ctl;

  logic signed [depq_pkg::DATA_W-1:0] cell_val [N];
  logic [N-1:0]                       cell_gt;
  logic [N:0]                         occ;
  logic [N-1:0]                       tail;

  logic signed [depq_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [depq_pkg::DATA_W-1:0] min_r, min_nxt;
  logic                               empty_r;
  logic [depq_pkg::CNT_W-1:0]         cnt_out_r;
  logic                               ovf_out_r;

  assign accept = start && !busy_r;

  always_comb begin
    ctl.ins_en  = accept && (in_command == depq_pkg::CMD_INSERT) && (count_r != FULL);
    ctl.del_min = accept && (in_command == depq_pkg::CMD_DEL_MIN) && (count_r != '0);
    ctl.value   = in_value;
  end

  // Thermometer of occupied slots; occ[N] is a constant zero guard.
  assign occ[N] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [depq_pkg::DATA_W-1:0] lv;
    logic signed [depq_pkg::DATA_W-1:0] rv;
    logic                               lg;

    assign occ[i]  = depq_pkg::CNT_W'(i) < count_r;
    assign tail[i] = depq_pkg::CNT_W'(i) == count_r;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    depq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .tail      (tail[i]),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val_o     (cell_val[i]),
      .gt_o      (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = 1'b0;
    out_valid_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
      ovf_nxt  = (in_command == depq_pkg::CMD_INSERT) && (count_r == FULL);
      if (ctl.ins_en) begin
        count_nxt = count_r + 1'b1;
      end else if (((in_command == depq_pkg::CMD_DEL_MAX) ||
                    (in_command == depq_pkg::CMD_DEL_MIN)) && (count_r != '0)) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  // The top occupied slot is the one whose right neighbor is free.
  always_comb begin
    max_nxt = '0;
    for (int i = 0; i < N; i++) begin
      max_nxt = max_nxt | (cell_val[i] & {depq_pkg::DATA_W{occ[i] && !occ[i+1]}});
    end
    min_nxt = occ[0] ? cell_val[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      empty_r   <= (count_r == '0);
      cnt_out_r <= count_r;
      ovf_out_r <= ovf_r;
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_max_value   = max_r;
  assign out_min_value   = min_r;
  assign out_is_empty    = empty_r;
  assign out_entry_count = cnt_out_r;
  assign out_overflow    = ovf_out_r;

`ifndef SYNTHESIS
  a_busy_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_valid_r)
    else $error("result strobe missing after compute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("stored count above capacity");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_overflow |-> (out_entry_count == FULL))
    else $error("overflow reported on a store with room");
`endif

endmodule
`default_nettype wire
